// ----- hdl/pcrc_pkg.sv -----
package pcrc_pkg;

	// Request kinds carried by req_type.
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_SEL  = 2'd2;

	// Action codes, also used as the kind of the running busy period.
	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_SHORT = 3'd1;
	localparam logic [2:0] ACT_LONG  = 3'd2;
	localparam logic [2:0] ACT_MENU  = 3'd3;
	localparam logic [2:0] ACT_DOOR  = 3'd4;

	// State of the first word seen in the startup window.
	localparam logic [1:0] MARK_UNSET = 2'd0;
	localparam logic [1:0] MARK_SET   = 2'd1;
	localparam logic [1:0] MARK_USED  = 2'd2;

	// Configuration register indexes.
	localparam logic [3:0] CFG_SHORT_COMBO  = 4'd0;
	localparam logic [3:0] CFG_LONG_COMBO   = 4'd1;
	localparam logic [3:0] CFG_DOOR_COMBO   = 4'd2;
	localparam logic [3:0] CFG_MENU_COMBO   = 4'd3;
	localparam logic [3:0] CFG_CANCEL_COMBO = 4'd4;
	localparam logic [3:0] CFG_WINDOW_MS    = 4'd5;
	localparam logic [3:0] CFG_SHORT_PULSE  = 4'd6;
	localparam logic [3:0] CFG_LONG_PULSE   = 4'd7;

	localparam logic [7:0]  HDR_TOP   = 8'h01;
	localparam logic [7:0]  HDR_READ  = 8'h42;
	localparam logic [15:0] IDLE_WORD = 16'hFFFF;
	localparam logic [15:0] DOOR_WAIT = 16'd700;

	// Byte parser phases.
	typedef enum logic [4:0] {
		PH_HDR  = 5'b00001,
		PH_CMD  = 5'b00010,
		PH_SKIP = 5'b00100,
		PH_LOW  = 5'b01000,
		PH_HIGH = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [15:0] short_combo;
		logic [15:0] long_combo;
		logic [15:0] door_combo;
		logic [15:0] menu_combo;
		logic [15:0] cancel_combo;
		logic [15:0] window_ms;
		logic [15:0] short_pulse_ms;
		logic [15:0] long_pulse_ms;
	} cfg_t;

	typedef struct packed {
		logic       reset_active;
		logic       door_line;
		logic [2:0] action;
		logic       busy_res;
	} res_t;

endpackage

// ----- hdl/pcrc_cfg.sv -----
module pcrc_cfg
	import pcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Indexes above the last register match no arm and are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_combo    <= 16'd64758;
			cfg_q.long_combo     <= 16'd48382;
			cfg_q.door_combo     <= 16'd62718;
			cfg_q.menu_combo     <= 16'd31998;
			cfg_q.cancel_combo   <= 16'd63487;
			cfg_q.window_ms      <= 16'd3000;
			cfg_q.short_pulse_ms <= 16'd700;
			cfg_q.long_pulse_ms  <= 16'd2000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_COMBO:  cfg_q.short_combo    <= cfg_data;
				CFG_LONG_COMBO:   cfg_q.long_combo     <= cfg_data;
				CFG_DOOR_COMBO:   cfg_q.door_combo     <= cfg_data;
				CFG_MENU_COMBO:   cfg_q.menu_combo     <= cfg_data;
				CFG_CANCEL_COMBO: cfg_q.cancel_combo   <= cfg_data;
				CFG_WINDOW_MS:    cfg_q.window_ms      <= cfg_data;
				CFG_SHORT_PULSE:  cfg_q.short_pulse_ms <= cfg_data;
				CFG_LONG_PULSE:   cfg_q.long_pulse_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/pcrc_core.sv -----
module pcrc_core
	import pcrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step_en,
	input  logic [1:0] req,
	input  logic [7:0] cmd,
	input  logic [7:0] dat,
	output res_t       res
);

	phase_t      phase_q, phase_n;
	logic [7:0]  low_q, low_n;
	logic [15:0] first_word_q, first_word_n;
	logic [1:0]  first_mark_q, first_mark_n;
	logic        win_open_q, win_open_n;
	logic [15:0] win_elapsed_q, win_elapsed_n;
	logic [15:0] busy_left_q, busy_left_n;
	logic [2:0]  busy_kind_q, busy_kind_n;
	logic        door_q, door_n;
	logic [15:0] word;
	logic [2:0]  cand;
	logic [2:0]  act;

	always_comb begin
		phase_n       = phase_q;
		low_n         = low_q;
		first_word_n  = first_word_q;
		first_mark_n  = first_mark_q;
		win_open_n    = win_open_q;
		win_elapsed_n = win_elapsed_q;
		busy_left_n   = busy_left_q;
		busy_kind_n   = busy_kind_q;
		door_n        = door_q;
		word          = {dat, low_q};
		cand          = ACT_NONE;
		act           = ACT_NONE;
		case (req)
			REQ_TICK: begin
				if (win_elapsed_q != IDLE_WORD) begin
					win_elapsed_n = win_elapsed_q + 16'd1;
				end
				if (busy_kind_q != ACT_NONE) begin
					if (busy_left_q > 16'd1) begin
						busy_left_n = busy_left_q - 16'd1;
					end else begin
						busy_left_n = '0;
						// The end of a reset pulse restarts the startup window.
						if (busy_kind_q != ACT_DOOR) begin
							win_open_n    = 1'b1;
							win_elapsed_n = '0;
							first_word_n  = '0;
							first_mark_n  = MARK_UNSET;
						end
						busy_kind_n = ACT_NONE;
					end
				end
			end
			REQ_BYTE: begin
				case (phase_q)
					PH_HDR: begin
						if (cmd == HDR_TOP) begin
							phase_n = PH_CMD;
						end
					end
					PH_CMD:  phase_n = (cmd == HDR_READ) ? PH_SKIP : PH_HDR;
					PH_SKIP: phase_n = PH_LOW;
					PH_LOW: begin
						low_n   = dat;
						phase_n = PH_HIGH;
					end
					default: begin
						phase_n = PH_HDR;
						if (win_open_q) begin
							if (win_elapsed_q > cfg.window_ms) begin
								win_open_n = 1'b0;
							end else if (word != IDLE_WORD && first_mark_q == MARK_UNSET) begin
								first_word_n = word;
								first_mark_n = MARK_SET;
							end
						end
						if (word == cfg.short_combo) begin
							cand = ACT_SHORT;
						end else if (word == cfg.long_combo) begin
							cand = ACT_LONG;
						end else if (word == cfg.door_combo) begin
							cand = ACT_DOOR;
						end else if (word == cfg.menu_combo) begin
							cand = ACT_MENU;
						end else if (word == cfg.cancel_combo) begin
							// The cancel word is used up even when the block is busy.
							if (win_open_n && first_mark_n == MARK_SET &&
							    (first_word_n & cfg.cancel_combo) != 16'd0) begin
								first_mark_n = MARK_USED;
								cand         = ACT_DOOR;
							end
						end
						if (cand != ACT_NONE && busy_kind_q == ACT_NONE) begin
							act         = cand;
							busy_kind_n = cand;
							case (cand)
								ACT_SHORT: begin
									door_n      = 1'b0;
									busy_left_n = (cfg.short_pulse_ms == 16'd0) ? 16'd1 :
									              cfg.short_pulse_ms;
								end
								ACT_LONG: begin
									door_n      = 1'b0;
									busy_left_n = (cfg.long_pulse_ms == 16'd0) ? 16'd1 :
									              cfg.long_pulse_ms;
								end
								ACT_MENU: begin
									door_n      = 1'b1;
									busy_left_n = (cfg.long_pulse_ms == 16'd0) ? 16'd1 :
									              cfg.long_pulse_ms;
								end
								default: begin
									door_n      = ~door_q;
									busy_left_n = DOOR_WAIT;
								end
							endcase
						end
					end
				endcase
			end
			REQ_SEL: phase_n = PH_HDR;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR;
			low_q         <= '0;
			first_word_q  <= '0;
			first_mark_q  <= MARK_UNSET;
			win_open_q    <= 1'b1;
			win_elapsed_q <= '0;
			busy_left_q   <= '0;
			busy_kind_q   <= ACT_NONE;
			door_q        <= 1'b0;
		end else if (step_en) begin
			phase_q       <= phase_n;
			low_q         <= low_n;
			first_word_q  <= first_word_n;
			first_mark_q  <= first_mark_n;
			win_open_q    <= win_open_n;
			win_elapsed_q <= win_elapsed_n;
			busy_left_q   <= busy_left_n;
			busy_kind_q   <= busy_kind_n;
			door_q        <= door_n;
		end
	end

	assign res.reset_active = (busy_kind_n == ACT_SHORT) || (busy_kind_n == ACT_LONG) ||
	                          (busy_kind_n == ACT_MENU);
	assign res.door_line    = door_n;
	assign res.action       = act;
	assign res.busy_res     = (busy_kind_n != ACT_NONE);

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parser phase lost its one-hot code");

	a_idle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_kind_q == ACT_NONE |-> busy_left_q == 16'd0)
		else $error("busy counter running with no busy kind");

	a_busy_counts: assert property (@(posedge clk) disable iff (!arst_n)
		busy_kind_q != ACT_NONE |-> busy_left_q != 16'd0)
		else $error("busy kind set with an empty counter");

	a_action_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && act != ACT_NONE |=> busy_kind_q != ACT_NONE)
		else $error("started action did not make the block busy");

endmodule

// ----- hdl/pad_combo_reset_controller.sv -----
// An accepted transfer is registered in the input stage, and its result is registered in
// the output stage when that item advances, which it cannot do while a result waits on out_stall.
// Throughput: one item per cycle while no result waits on out_stall; the only loop is the core's state update.
// While a result waits on out_stall the input stage still takes one transfer, then stalls.
// Reset: arst_n clears the parser, timers, window and door state at once and loads
// the configuration registers with their default combinations and times.
module pad_combo_reset_controller
	import pcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  cmd_byte,
	input  logic [7:0]  dat_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reset_active,
	output logic        door_line,
	output logic [2:0]  action,
	output logic        busy_res,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Input stage: one registered item waiting for the state update.
	logic       valid_s1;
	logic [1:0] req_s1;
	logic [7:0] cmd_s1;
	logic [7:0] dat_s1;

	// Output stage: the registered result.
	logic out_valid_q;
	res_t res_q;

	cfg_t cfg;
	res_t res;
	logic advance;
	logic in_take;

	// The item in the input stage is processed in the cycle it moves into the
	// output register, which happens whenever that register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);

	// The input stage accepts when it is empty or is handing its item on.
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	pcrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcrc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (advance),
		.req     (req_s1),
		.cmd     (cmd_s1),
		.dat     (dat_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= req_type;
			cmd_s1 <= cmd_byte;
			dat_s1 <= dat_byte;
		end
	end

	// A result leaves on an unstalled transfer; a new one may land in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign reset_active = res_q.reset_active;
	assign door_line    = res_q.door_line;
	assign action       = res_q.action;
	assign busy_res     = res_q.busy_res;

endmodule
